>>> hdl/lru_pkg.sv
// Shared types and constants for the LRU page replacement block.
package lru_pkg;

  // Default sizing of the frame table.
  localparam int unsigned FrameCountDef = 16;
  localparam int unsigned PageBitsDef   = 16;

  // Fixed widths of the external fields.
  localparam int unsigned CfgW       = 5;
  localparam int unsigned PageFieldW = 16;
  localparam int unsigned FrameFieldW = 4;
  localparam int unsigned CountW     = 32;

  // Reset value of the frames-in-use register.
  localparam logic [CfgW-1:0] FramesInUseRst = 5'd16;

  // Status that travels down the cell chain with a lookup.
  typedef struct packed {
    logic tok;   // a lookup is present in this stage
    logic hit;   // an active valid frame holds the page
    logic free;  // an active empty frame was seen
    logic seen;  // at least one active frame was seen
  } scan_flags_t;

  // Frame update issued to the cells when a lookup commits.
  typedef struct packed {
    logic en;        // refresh the stamp of the selected frame
    logic set_page;  // also load the page and mark the frame valid
  } frame_wr_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StLaunch,
    StScan,
    StCommit
  } lru_state_e;

endpackage

>>> hdl/lru_cell.sv
// One frame of the table together with its stage of the lookup chain.
module lru_cell #(
  parameter int unsigned PAGE_BITS = lru_pkg::PageBitsDef,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      active_i,
  input  logic [PAGE_BITS-1:0]      req_page_i,
  input  logic [lru_pkg::CountW-1:0] ref_clock_i,
  input  lru_pkg::frame_wr_t        wr_i,
  input  logic [IDX_W-1:0]          wr_idx_i,
  input  lru_pkg::scan_flags_t      flags_i,
  input  logic [IDX_W-1:0]          hit_idx_i,
  input  logic [IDX_W-1:0]          free_idx_i,
  input  logic [IDX_W-1:0]          lru_idx_i,
  input  logic [lru_pkg::CountW-1:0] lru_age_i,
  input  logic [PAGE_BITS-1:0]      lru_page_i,
  output lru_pkg::scan_flags_t      flags_o,
  output logic [IDX_W-1:0]          hit_idx_o,
  output logic [IDX_W-1:0]          free_idx_o,
  output logic [IDX_W-1:0]          lru_idx_o,
  output logic [lru_pkg::CountW-1:0] lru_age_o,
  output logic [PAGE_BITS-1:0]      lru_page_o
);
  import lru_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  // Frame contents.
  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic [CountW-1:0]    stamp_q;

  // Stage outputs handed to the next cell.
  scan_flags_t          flags_q, flags_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]     free_idx_q, free_idx_d;
  logic [IDX_W-1:0]     lru_idx_q, lru_idx_d;
  logic [CountW-1:0]    lru_age_q, lru_age_d;
  logic [PAGE_BITS-1:0] lru_page_q, lru_page_d;

  logic                 hit_here;
  logic                 free_here;
  logic [CountW-1:0]    age;
  logic                 take_lru;
  logic                 wr_sel;

  // Local lookup: match, emptiness and age of this frame.
  assign hit_here  = active_i && valid_q && (page_q == req_page_i);
  assign free_here = active_i && !valid_q;
  assign age       = ref_clock_i - stamp_q;
  assign take_lru  = active_i && (!flags_i.seen || (age > lru_age_i));
  assign wr_sel    = wr_i.en && (wr_idx_i == MyIdx);

  // Merge this frame into the running lookup result; lower frames win ties.
  always_comb begin
    flags_d.tok  = flags_i.tok;
    flags_d.hit  = flags_i.hit  || hit_here;
    flags_d.free = flags_i.free || free_here;
    flags_d.seen = flags_i.seen || active_i;
    hit_idx_d    = flags_i.hit  ? hit_idx_i  : MyIdx;
    free_idx_d   = flags_i.free ? free_idx_i : MyIdx;
    if (take_lru) begin
      lru_idx_d  = MyIdx;
      lru_age_d  = age;
      lru_page_d = page_q;
    end else begin
      lru_idx_d  = lru_idx_i;
      lru_age_d  = lru_age_i;
      lru_page_d = lru_page_i;
    end
  end

  // Stage register; the data holds once the lookup has passed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (flags_i.tok) begin
      flags_q <= flags_d;
    end else begin
      flags_q.tok <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flags_i.tok) begin
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
      lru_idx_q  <= lru_idx_d;
      lru_age_q  <= lru_age_d;
      lru_page_q <= lru_page_d;
    end
  end

  // Frame state: valid bit and stamp are reset, the page is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      stamp_q <= '0;
    end else if (wr_sel) begin
      stamp_q <= ref_clock_i;
      if (wr_i.set_page) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel && wr_i.set_page) begin
      page_q <= req_page_i;
    end
  end

  assign flags_o    = flags_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign lru_idx_o  = lru_idx_q;
  assign lru_age_o  = lru_age_q;
  assign lru_page_o = lru_page_q;

endmodule

>>> hdl/lru_page_replacement_top.sv
// Top level of the LRU page replacement block: sequencer and chain of frame cells.
//
// Usage:
//   Page references enter on the input channel (in_valid_i / in_ready_o with
//   page_number_i). Each reference yields exactly one result transaction on
//   the output channel (out_valid_o / out_ready_i) carrying hit_o,
//   frame_used_o, evicted_valid_o, evicted_page_o and fault_total_o.
//   A lookup walks the chain of frame cells, one cell per cycle; the block
//   takes no new reference until the current one has been committed to the
//   output register, since in_ready_o is high only while the sequencer idles.
//   The number of frames taking part is written through cfg_we_i and
//   cfg_wdata_i; the user must write it only while the block is idle, which
//   the block itself does not enforce; 0 acts as 1 and values above
//   FRAME_COUNT act as FRAME_COUNT.
//   Reset empties every frame, clears all stamps, the reference clock and the
//   fault count, and sets the frames-in-use register to 16.
//   If the receiver stalls, the result stays in the output register and the
//   next reference is still accepted and looked up; its commit waits until
//   the output register is free.
module lru_page_replacement_top #(
  parameter int unsigned FRAME_COUNT = lru_pkg::FrameCountDef,
  parameter int unsigned PAGE_BITS   = lru_pkg::PageBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lru_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lru_pkg::PageFieldW-1:0] page_number_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic [lru_pkg::FrameFieldW-1:0] frame_used_o,
  output logic                           evicted_valid_o,
  output logic [lru_pkg::PageFieldW-1:0] evicted_page_o,
  output logic [lru_pkg::CountW-1:0]     fault_total_o
);
  import lru_pkg::*;

  localparam int unsigned IdxW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  // Control registers.
  lru_state_e           state_q, state_d;
  logic [CfgW-1:0]      frames_in_use_q;
  logic [CountW-1:0]    ref_clock_q;
  logic [CountW-1:0]    fault_q, fault_d;
  logic [PAGE_BITS-1:0] req_page_q;

  // Output register.
  logic                   out_valid_q;
  logic                   hit_q;
  logic [FrameFieldW-1:0] frame_used_q;
  logic                   evicted_valid_q;
  logic [PageFieldW-1:0]  evicted_page_q;
  logic [CountW-1:0]      fault_total_q;

  // Sequencer outputs.
  logic accept;
  logic launch;
  logic commit;
  logic out_free;

  // Chain wiring; index 0 is the seed, index FRAME_COUNT the last stage.
  scan_flags_t          ch_flags [FRAME_COUNT+1];
  logic [IdxW-1:0]      ch_hit_idx [FRAME_COUNT+1];
  logic [IdxW-1:0]      ch_free_idx [FRAME_COUNT+1];
  logic [IdxW-1:0]      ch_lru_idx [FRAME_COUNT+1];
  logic [CountW-1:0]    ch_lru_age [FRAME_COUNT+1];
  logic [PAGE_BITS-1:0] ch_lru_page [FRAME_COUNT+1];

  // Commit decision.
  scan_flags_t     res_flags;
  logic            evict;
  logic [IdxW-1:0] slot;
  frame_wr_t       wr;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StLaunch;
      StLaunch: state_d = StScan;
      StScan:   if (ch_flags[FRAME_COUNT].tok) state_d = StCommit;
      StCommit: if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready_o = 1'b0;
    launch     = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      StIdle:   in_ready_o = 1'b1;
      StLaunch: launch = 1'b1;
      StScan:   ;
      StCommit: commit = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FramesInUseRst;
    end else if (cfg_we_i) begin
      frames_in_use_q <= cfg_wdata_i;
    end
  end

  // Captured reference.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_page_q <= PAGE_BITS'(page_number_i);
    end
  end

  // Chain seed: a fresh lookup with nothing found yet.
  always_comb begin
    ch_flags[0]      = '0;
    ch_flags[0].tok  = launch;
    ch_hit_idx[0]    = '0;
    ch_free_idx[0]   = '0;
    ch_lru_idx[0]    = '0;
    ch_lru_age[0]    = '0;
    ch_lru_page[0]   = '0;
  end

  // Row of frame cells.
  for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
    logic active;

    // Frame 0 is always active; others while below the configured count.
    assign active = (g == 0) || (int'(frames_in_use_q) > g);

    lru_cell #(
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IdxW),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .active_i    (active),
      .req_page_i  (req_page_q),
      .ref_clock_i (ref_clock_q),
      .wr_i        (wr),
      .wr_idx_i    (slot),
      .flags_i     (ch_flags[g]),
      .hit_idx_i   (ch_hit_idx[g]),
      .free_idx_i  (ch_free_idx[g]),
      .lru_idx_i   (ch_lru_idx[g]),
      .lru_age_i   (ch_lru_age[g]),
      .lru_page_i  (ch_lru_page[g]),
      .flags_o     (ch_flags[g+1]),
      .hit_idx_o   (ch_hit_idx[g+1]),
      .free_idx_o  (ch_free_idx[g+1]),
      .lru_idx_o   (ch_lru_idx[g+1]),
      .lru_age_o   (ch_lru_age[g+1]),
      .lru_page_o  (ch_lru_page[g+1])
    );
  end

  // Pick the frame: hit first, then lowest empty frame, then the LRU victim.
  always_comb begin
    res_flags   = ch_flags[FRAME_COUNT];
    evict       = !res_flags.hit && !res_flags.free;
    if (res_flags.hit) begin
      slot = ch_hit_idx[FRAME_COUNT];
    end else if (res_flags.free) begin
      slot = ch_free_idx[FRAME_COUNT];
    end else begin
      slot = ch_lru_idx[FRAME_COUNT];
    end
    wr.en       = commit;
    wr.set_page = commit && !res_flags.hit;
    fault_d     = (!res_flags.hit && (fault_q != '1)) ? fault_q + CountW'(1) : fault_q;
  end

  // Reference clock advances on every commit; the fault count on a commit that misses, saturating at its maximum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_clock_q <= '0;
      fault_q     <= '0;
    end else if (commit) begin
      ref_clock_q <= ref_clock_q + CountW'(1);
      fault_q     <= fault_d;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q           <= res_flags.hit;
      frame_used_q    <= FrameFieldW'(slot);
      evicted_valid_q <= evict;
      evicted_page_q  <= evict ? PageFieldW'(ch_lru_page[FRAME_COUNT]) : '0;
      fault_total_q   <= fault_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_used_o    = frame_used_q;
  assign evicted_valid_o = evicted_valid_q;
  assign evicted_page_o  = evicted_page_q;
  assign fault_total_o   = fault_total_q;

endmodule

>>> hdl/lru_chk.sv
// Port-level checker for the LRU page replacement block, with its bind.
module lru_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           hit_o,
  input logic [lru_pkg::FrameFieldW-1:0] frame_used_o,
  input logic                           evicted_valid_o,
  input logic [lru_pkg::PageFieldW-1:0] evicted_page_o,
  input logic [lru_pkg::CountW-1:0]     fault_total_o
);
  import lru_pkg::*;

  // A stalled result transaction holds its payload (all fields but evicted_valid_o are checked).
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
      $stable(frame_used_o) && $stable(evicted_page_o) && $stable(fault_total_o))
    else $error("result changed while stalled");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o)
    else $error("eviction reported on a hit");

  // Without eviction the evicted page reads zero.
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> evicted_page_o == '0)
    else $error("evicted page nonzero without eviction");

  // A miss has counted at least one fault.
  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> fault_total_o != '0)
    else $error("miss with zero fault total");

  // One reference is looked up at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("reference accepted during a lookup");

endmodule

bind lru_page_replacement_top lru_chk u_lru_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .hit_o           (hit_o),
  .frame_used_o    (frame_used_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o),
  .fault_total_o   (fault_total_o)
);
